// ===== hw/rtl/mac_keyed_target_table_assert.svh =====
// Assertion macros for the MAC keyed target table.
`ifndef MAC_KEYED_TARGET_TABLE_ASSERT_SVH
`define MAC_KEYED_TARGET_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define MKT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MKT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MKT_ASSERT(label, clk, rst, prop, msg)
`define MKT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/mkt_pkg.sv =====
// Shared types and constants for the MAC keyed target table.
package mkt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int IDX_MAX_W     = 6;
   localparam int CNT_MAX_W     = IDX_MAX_W + 1;
   localparam int MAC_W         = 48;
   localparam int TIME_W        = 32;
   localparam int HITS_W        = 32;
   localparam int SLOT_W        = 4;
   localparam int CNT_OUT_W     = 5;

   localparam logic [TIME_W-1:0] EXPIRE_RESET = 32'd10000;

   typedef enum logic {
      OP_OBSERVE = 1'b0,
      OP_SWEEP   = 1'b1
   } op_type;

   typedef enum logic {
      LINK_WIFI = 1'b0,
      LINK_BLE  = 1'b1
   } link_type;

   typedef struct packed {
      logic [MAC_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
      logic [HITS_W-1:0] hits;
   } entry_type;

   typedef struct packed {
      logic                 clear;
      logic                 check;
      logic                 sweep;
      logic [IDX_MAX_W-1:0] idx;
      logic                 entry_valid;
   } scan_ctrl_type;

   typedef struct packed {
      logic                 match;
      logic [IDX_MAX_W-1:0] match_idx;
      logic [HITS_W-1:0]    match_hits;
      logic                 free_found;
      logic [IDX_MAX_W-1:0] free_idx;
      logic [IDX_MAX_W-1:0] oldest_idx;
      logic                 expired;
      logic [CNT_MAX_W-1:0] removed;
   } scan_stat_type;

endpackage

// ===== hw/rtl/mkt_entry_ram.sv =====
// Entry store with one write port and one registered read port.
module mkt_entry_ram #(
   parameter int DEPTH = mkt_pkg::SLOTS_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  mkt_pkg::entry_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output mkt_pkg::entry_type  rd_data
);
   import mkt_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mkt_scan_unit.sv =====
// Shared compare unit that accumulates match, free, oldest and expiry results over a scan.
module mkt_scan_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  mkt_pkg::scan_ctrl_type            ctrl,
   input  logic [mkt_pkg::MAC_W-1:0]         mac,
   input  logic [mkt_pkg::TIME_W-1:0]        now_time,
   input  logic [mkt_pkg::TIME_W-1:0]        expire_time,
   input  mkt_pkg::entry_type                rd_entry,
   output mkt_pkg::scan_stat_type            stat
);
   import mkt_pkg::*;

   logic                 match_ff;
   logic                 free_ff;
   logic [CNT_MAX_W-1:0] removed_ff;
   logic [IDX_MAX_W-1:0] match_idx_ff;
   logic [HITS_W-1:0]    match_hits_ff;
   logic [IDX_MAX_W-1:0] free_idx_ff;
   logic [IDX_MAX_W-1:0] oldest_idx_ff;
   logic [TIME_W-1:0]    oldest_time_ff;

   logic [TIME_W-1:0]    age;
   logic [TIME_W-1:0]    cmp_a;
   logic [TIME_W-1:0]    cmp_b;
   logic                 cmp_lt;
   logic                 key_hit;
   logic                 expired;
   logic                 observe_chk;

   // One comparator serves both the oldest search and the age test.
   always_comb begin
      age = now_time - rd_entry.stamp;
      if (ctrl.sweep) begin
         cmp_a = expire_time;
         cmp_b = age;
      end else begin
         cmp_a = rd_entry.stamp;
         cmp_b = oldest_time_ff;
      end
      cmp_lt      = cmp_a < cmp_b;
      key_hit     = ctrl.entry_valid && (rd_entry.key == mac);
      expired     = ctrl.check && ctrl.sweep && ctrl.entry_valid && cmp_lt;
      observe_chk = ctrl.check && !ctrl.sweep;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         match_ff   <= 1'b0;
         free_ff    <= 1'b0;
         removed_ff <= '0;
      end else if (ctrl.check) begin
         if (ctrl.sweep) begin
            removed_ff <= removed_ff + CNT_MAX_W'(expired);
         end else begin
            if (key_hit && !match_ff) begin
               match_ff <= 1'b1;
            end
            if (!ctrl.entry_valid && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (observe_chk) begin
         if (key_hit && !match_ff) begin
            match_idx_ff  <= ctrl.idx;
            match_hits_ff <= rd_entry.hits;
         end
         if (!ctrl.entry_valid && !free_ff) begin
            free_idx_ff <= ctrl.idx;
         end
         if ((ctrl.idx == '0) || cmp_lt) begin
            oldest_idx_ff  <= ctrl.idx;
            oldest_time_ff <= rd_entry.stamp;
         end
      end
   end

   always_comb begin
      stat.match      = match_ff;
      stat.match_idx  = match_idx_ff;
      stat.match_hits = match_hits_ff;
      stat.free_found = free_ff;
      stat.free_idx   = free_idx_ff;
      stat.oldest_idx = oldest_idx_ff;
      stat.expired    = expired;
      stat.removed    = removed_ff;
   end

endmodule

// ===== hw/rtl/mac_keyed_target_table.sv =====
// Top level of the MAC keyed target table: sequencer, valid bits, counters and result register.
//
// The table holds SLOTS entries keyed by a 48-bit MAC. A request beat on req_* either
// observes a frame (operation 0) or runs an expiry sweep (operation 1). Each request
// produces exactly one response beat on rsp_*. csr_wr_en writes the expiry age in
// milliseconds from csr_wr_data at the next clock edge; write it only while the block
// is idle.
// Every request walks all slots through the single read port of the entry store and
// one shared compare unit, one slot per cycle. The response is registered in the commit
// state, after the scan and drain states, and a new request is taken only once the
// sequencer has returned to idle after that commit.
// req_ready is high only while the sequencer is idle. A finished response waits in the
// output register; the next request may be accepted and scanned meanwhile, and its
// commit stalls until the pending response beat has been taken.
// Synchronous reset empties the table, clears all counters and the response valid flag,
// and restores the expiry age to 10000 ms. The entry store needs no clearing pass
// because every slot is qualified by a valid bit.
`include "mac_keyed_target_table_assert.svh"
module mac_keyed_target_table #(
   parameter int SLOTS = mkt_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic [mkt_pkg::MAC_W-1:0]          req_mac,
   input  logic [mkt_pkg::TIME_W-1:0]         req_now_time,
   input  logic                               req_link,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mkt_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_matched,
   output logic                               rsp_evicted,
   output logic [mkt_pkg::HITS_W-1:0]         rsp_entry_hits,
   output logic [mkt_pkg::HITS_W-1:0]         rsp_total_count,
   output logic [mkt_pkg::HITS_W-1:0]         rsp_bluetooth_count,
   output logic [mkt_pkg::HITS_W-1:0]         rsp_wifi_count,
   output logic [mkt_pkg::CNT_OUT_W-1:0]      rsp_removed_count,
   output logic [mkt_pkg::CNT_OUT_W-1:0]      rsp_active_count,
   input  logic                               csr_wr_en,
   input  logic [mkt_pkg::TIME_W-1:0]         csr_wr_data
);
   import mkt_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     entry_valid_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic                 chk_ff;
   logic                 chk_valid_ff;
   logic [CNT_W-1:0]     active_ff, active_in;
   logic [HITS_W-1:0]    total_ff, total_in;
   logic [HITS_W-1:0]    ble_ff, ble_in;
   logic [HITS_W-1:0]    wifi_ff, wifi_in;
   logic [TIME_W-1:0]    expire_ff;

   op_type               op_ff;
   link_type             link_ff;
   logic [MAC_W-1:0]     mac_ff;
   logic [TIME_W-1:0]    now_ff;

   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_matched_ff;
   logic                 rsp_evicted_ff;
   logic [HITS_W-1:0]    rsp_hits_ff;
   logic [HITS_W-1:0]    rsp_total_ff;
   logic [HITS_W-1:0]    rsp_ble_ff;
   logic [HITS_W-1:0]    rsp_wifi_ff;
   logic [CNT_OUT_W-1:0] rsp_removed_ff;
   logic [CNT_OUT_W-1:0] rsp_active_ff;

   logic                 req_fire;
   logic                 commit_go;
   logic                 scan_last;
   logic                 is_sweep;
   logic [IDX_W-1:0]     pick_idx;
   logic [HITS_W-1:0]    new_hits;
   logic                 ram_wr_en;
   entry_type            ram_wr_data;
   entry_type            ram_rd_data;
   scan_ctrl_type        scan_ctrl;
   scan_stat_type        scan_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign scan_last = (rd_idx_ff == IDX_W'(SLOTS - 1));
   assign is_sweep  = (op_ff == OP_SWEEP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      scan_ctrl.clear       = req_fire;
      scan_ctrl.check       = chk_ff;
      scan_ctrl.sweep       = is_sweep;
      scan_ctrl.idx         = IDX_MAX_W'(chk_idx_ff);
      scan_ctrl.entry_valid = chk_valid_ff;
   end

   mkt_scan_unit u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .mac         (mac_ff),
      .now_time    (now_ff),
      .expire_time (expire_ff),
      .rd_entry    (ram_rd_data),
      .stat        (scan_stat)
   );

   always_comb begin
      if (scan_stat.match) begin
         pick_idx = scan_stat.match_idx[IDX_W-1:0];
         new_hits = scan_stat.match_hits + HITS_W'(1);
      end else if (scan_stat.free_found) begin
         pick_idx = scan_stat.free_idx[IDX_W-1:0];
         new_hits = HITS_W'(1);
      end else begin
         pick_idx = scan_stat.oldest_idx[IDX_W-1:0];
         new_hits = HITS_W'(1);
      end
      ram_wr_en         = commit_go && !is_sweep;
      ram_wr_data.key   = mac_ff;
      ram_wr_data.stamp = now_ff;
      ram_wr_data.hits  = new_hits;
   end

   mkt_entry_ram #(
      .DEPTH (SLOTS),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_idx),
      .wr_data (ram_wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      active_in = active_ff;
      total_in  = total_ff;
      ble_in    = ble_ff;
      wifi_in   = wifi_ff;
      if (is_sweep) begin
         active_in = active_ff - scan_stat.removed[CNT_W-1:0];
      end else begin
         if (!scan_stat.match && scan_stat.free_found) begin
            active_in = active_ff + CNT_W'(1);
         end
         total_in = total_ff + HITS_W'(1);
         if (link_ff == LINK_BLE) begin
            ble_in = ble_ff + HITS_W'(1);
         end else begin
            wifi_in = wifi_ff + HITS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         rd_idx_ff      <= '0;
         chk_ff         <= 1'b0;
         active_ff      <= '0;
         total_ff       <= '0;
         ble_ff         <= '0;
         wifi_ff        <= '0;
         expire_ff      <= EXPIRE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= (state_ff == ST_SCAN);
         if (req_fire) begin
            rd_idx_ff <= '0;
         end else if ((state_ff == ST_SCAN) && !scan_last) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
         if (scan_stat.expired) begin
            entry_valid_ff[chk_idx_ff] <= 1'b0;
         end
         if (commit_go) begin
            if (!is_sweep) begin
               entry_valid_ff[pick_idx] <= 1'b1;
            end
            active_ff <= active_in;
            total_ff  <= total_in;
            ble_ff    <= ble_in;
            wifi_ff   <= wifi_in;
         end
         if (csr_wr_en) begin
            expire_ff <= csr_wr_data;
         end
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff   <= rd_idx_ff;
      chk_valid_ff <= entry_valid_ff[rd_idx_ff];
      if (req_fire) begin
         op_ff   <= op_type'(req_operation);
         link_ff <= link_type'(req_link);
         mac_ff  <= req_mac;
         now_ff  <= req_now_time;
      end
      if (commit_go) begin
         rsp_total_ff  <= total_in;
         rsp_ble_ff    <= ble_in;
         rsp_wifi_ff   <= wifi_in;
         rsp_active_ff <= CNT_OUT_W'(active_in);
         if (is_sweep) begin
            rsp_slot_ff    <= '0;
            rsp_matched_ff <= 1'b0;
            rsp_evicted_ff <= 1'b0;
            rsp_hits_ff    <= '0;
            rsp_removed_ff <= CNT_OUT_W'(scan_stat.removed);
         end else begin
            rsp_slot_ff    <= SLOT_W'(pick_idx);
            rsp_matched_ff <= scan_stat.match;
            rsp_evicted_ff <= !scan_stat.match && !scan_stat.free_found;
            rsp_hits_ff    <= new_hits;
            rsp_removed_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_matched         = rsp_matched_ff;
   assign rsp_evicted         = rsp_evicted_ff;
   assign rsp_entry_hits      = rsp_hits_ff;
   assign rsp_total_count     = rsp_total_ff;
   assign rsp_bluetooth_count = rsp_ble_ff;
   assign rsp_wifi_count      = rsp_wifi_ff;
   assign rsp_removed_count   = rsp_removed_ff;
   assign rsp_active_count    = rsp_active_ff;

   `MKT_ASSERT(a_active_tracks_valid, clock, reset, (state_ff == ST_IDLE) |-> ($countones(entry_valid_ff) == int'(active_ff)), "active count differs from valid bits")
   `MKT_ASSERT(a_expire_only_in_scan, clock, reset, scan_stat.expired |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)), "expiry outside of a scan")
   `MKT_ASSERT(a_match_not_evict, clock, reset, rsp_valid_ff |-> !(rsp_matched_ff && rsp_evicted_ff), "response both matched and evicted")
   `MKT_ASSERT_ALWAYS(a_active_bounded, clock, reset || (int'(active_ff) <= SLOTS), "active count above table size")

endmodule
